/* design/imh_pkg.sv */
`default_nettype none
package imh_pkg;

   localparam int HEAP_DEPTH_DEF   = 255;
   localparam int HANDLE_LIMIT_DEF = 1023;
   localparam int KEY_BITS_DEF     = 32;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_TOP    = 3'd1,
      CMD_POP    = 3'd2,
      CMD_UPDATE = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_GET    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NO_HANDLE = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HDATA,
      S_KDATA,
      S_UP,
      S_UPCMP,
      S_TOPDATA,
      S_ROOTDATA,
      S_LASTDATA,
      S_DOWN,
      S_LEFT,
      S_RIGHT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] key_in;
      logic [9:0]         handle_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [9:0]         handle_out;
      logic signed [31:0] key_out;
      logic [7:0]         count;
   } rsp_type;

endpackage
`default_nettype wire

/* design/imh_ram.sv */
`default_nettype none
module imh_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_mem [DEPTH];

   always_ff @(posedge clock) begin
      rd_data <= store_mem[rd_addr];
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end
endmodule
`default_nettype wire

/* design/indexed_min_heap_core.sv */
`default_nettype none
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  command, key_in, handle_in
// rsp_      out        rsp_valid / rsp_stall  status, handle_out, key_out, count
//
// one transaction at a time; the longest is a remove, set by the sift loops:
// the removed entry climbs from its slot to the root through S_UP and S_UPCMP, then the
// last entry sinks back down through S_DOWN, S_LEFT and S_RIGHT (left, right read)
// reset is synchronous; no clearing pass, handle table entries are only read
// below the next free handle, which insert writes in order
// a finished result waits in the output register while rsp_stall is high
module indexed_min_heap_core
#(
   parameter int HEAP_DEPTH   = imh_pkg::HEAP_DEPTH_DEF,
   parameter int HANDLE_LIMIT = imh_pkg::HANDLE_LIMIT_DEF,
   parameter int KEY_BITS     = imh_pkg::KEY_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire imh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output imh_pkg::rsp_type      rsp_data
);
   import imh_pkg::*;

   localparam int SW = $clog2(HEAP_DEPTH + 1);
   localparam int HW = $clog2(HANDLE_LIMIT + 1);
   localparam int NW = $clog2(HANDLE_LIMIT + 2);
   localparam int KW = KEY_BITS;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [SW-1:0] count_ff, count_in;
   logic [NW-1:0] nf_ff, nf_in;
   logic [SW-1:0] i_ff, i_in;
   logic signed [KW-1:0] key_ff, key_in;
   logic signed [KW-1:0] cur_key_ff, cur_key_in;
   logic [HW-1:0] cur_h_ff, cur_h_in;
   logic signed [KW-1:0] best_key_ff, best_key_in;
   logic [HW-1:0] best_h_ff, best_h_in;
   logic [SW-1:0] best_i_ff, best_i_in;
   status_type st_ff, st_in;
   logic [HW-1:0] ho_ff, ho_in;
   logic signed [KW-1:0] ko_ff, ko_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic heap_we;
   logic [SW-1:0] heap_wa, heap_ra;
   logic [KW+HW-1:0] heap_wd, heap_rd;
   logic hs_we;
   logic [HW-1:0] hs_wa, hs_ra;
   logic [SW-1:0] hs_wd, hs_rd;

   logic signed [KW-1:0] rd_key;
   logic [HW-1:0] rd_h;
   logic signed [KW-1:0] key_ext;
   logic accept;

   assign rd_key = $signed(heap_rd[KW+HW-1:HW]);
   assign rd_h = heap_rd[HW-1:0];
   assign key_ext = $signed(KW'($unsigned(req_data.key_in)));
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   imh_ram #(.DEPTH(HEAP_DEPTH + 1), .WIDTH(KW + HW)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr(heap_ra), .rd_data(heap_rd)
   );

   imh_ram #(.DEPTH(HANDLE_LIMIT + 1), .WIDTH(SW)) u_slots (
      .clock(clock), .wr_en(hs_we), .wr_addr(hs_wa), .wr_data(hs_wd),
      .rd_addr(hs_ra), .rd_data(hs_rd)
   );

   always_comb begin
      logic place;
      logic decide;
      logic signed [KW-1:0] d_key;
      logic [HW-1:0] d_h;
      logic [SW-1:0] d_i;
      logic [SW:0] lft;
      logic [SW:0] rgt;
      logic hvalid;

      place = 1'b0;
      decide = 1'b0;
      d_key = best_key_ff;
      d_h = best_h_ff;
      d_i = best_i_ff;
      lft = {i_ff, 1'b0};
      rgt = {i_ff, 1'b1};
      hvalid = (req_data.handle_in != '0)
         && (32'(req_data.handle_in) <= 32'(HANDLE_LIMIT))
         && (32'(req_data.handle_in) < 32'(nf_ff));

      state_in = state_ff;
      cmd_in = cmd_ff;
      count_in = count_ff;
      nf_in = nf_ff;
      i_in = i_ff;
      key_in = key_ff;
      cur_key_in = cur_key_ff;
      cur_h_in = cur_h_ff;
      best_key_in = best_key_ff;
      best_h_in = best_h_ff;
      best_i_in = best_i_ff;
      st_in = st_ff;
      ho_in = ho_ff;
      ko_in = ko_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      heap_we = 1'b0;
      heap_wa = '0;
      heap_wd = '0;
      heap_ra = '0;
      hs_we = 1'b0;
      hs_wa = '0;
      hs_wd = '0;
      hs_ra = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = cmd_type'(req_data.command);
               key_in = key_ext;
               st_in = STAT_OK;
               ho_in = '0;
               ko_in = '0;
               cur_h_in = HW'(req_data.handle_in);
               state_in = S_DONE;
               case (cmd_type'(req_data.command))
                  CMD_INSERT: begin
                     if (32'(count_ff) >= 32'(HEAP_DEPTH)
                         || 32'(nf_ff) > 32'(HANDLE_LIMIT)) begin
                        st_in = STAT_FULL;
                     end else begin
                        count_in = SW'(count_ff + 1'b1);
                        i_in = SW'(count_ff + 1'b1);
                        cur_key_in = key_ext;
                        cur_h_in = HW'(nf_ff);
                        ho_in = HW'(nf_ff);
                        nf_in = NW'(nf_ff + 1'b1);
                        state_in = S_UP;
                     end
                  end
                  CMD_TOP, CMD_POP: begin
                     if (count_ff == '0) begin
                        st_in = STAT_EMPTY;
                     end else begin
                        heap_ra = SW'(1);
                        state_in = (cmd_type'(req_data.command) == CMD_TOP)
                           ? S_TOPDATA : S_ROOTDATA;
                     end
                  end
                  CMD_UPDATE, CMD_REMOVE, CMD_GET: begin
                     if (!hvalid) begin
                        st_in = STAT_NO_HANDLE;
                     end else begin
                        hs_ra = HW'(req_data.handle_in);
                        state_in = S_HDATA;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_HDATA: begin
            if (hs_rd == '0) begin
               st_in = STAT_NO_HANDLE;
               state_in = S_DONE;
            end else begin
               i_in = hs_rd;
               heap_ra = hs_rd;
               state_in = S_KDATA;
            end
         end
         S_KDATA: begin
            case (cmd_ff)
               CMD_GET: begin
                  ko_in = rd_key;
                  state_in = S_DONE;
               end
               CMD_UPDATE: begin
                  cur_key_in = key_ff;
                  state_in = (key_ff < rd_key) ? S_UP : S_DOWN;
               end
               default: begin
                  state_in = S_UP;
               end
            endcase
         end
         S_UP: begin
            if (i_ff == SW'(1)) begin
               if (cmd_ff == CMD_REMOVE) begin
                  hs_we = 1'b1;
                  hs_wa = cur_h_ff;
                  hs_wd = '0;
                  heap_ra = count_ff;
                  state_in = S_LASTDATA;
               end else begin
                  place = 1'b1;
               end
            end else begin
               heap_ra = i_ff >> 1;
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if (cmd_ff == CMD_REMOVE || cur_key_ff < rd_key) begin
               heap_we = 1'b1;
               heap_wa = i_ff;
               heap_wd = heap_rd;
               hs_we = 1'b1;
               hs_wa = rd_h;
               hs_wd = i_ff;
               i_in = i_ff >> 1;
               state_in = S_UP;
            end else begin
               place = 1'b1;
            end
         end
         S_TOPDATA: begin
            ho_in = rd_h;
            ko_in = rd_key;
            state_in = S_DONE;
         end
         S_ROOTDATA: begin
            ho_in = rd_h;
            ko_in = rd_key;
            hs_we = 1'b1;
            hs_wa = rd_h;
            hs_wd = '0;
            heap_ra = count_ff;
            state_in = S_LASTDATA;
         end
         S_LASTDATA: begin
            count_in = SW'(count_ff - 1'b1);
            cur_key_in = rd_key;
            cur_h_in = rd_h;
            i_in = SW'(1);
            state_in = (count_ff == SW'(1)) ? S_DONE : S_DOWN;
         end
         S_DOWN: begin
            if (lft > {1'b0, count_ff}) begin
               place = 1'b1;
            end else begin
               heap_ra = lft[SW-1:0];
               state_in = S_LEFT;
            end
         end
         S_LEFT: begin
            if (rd_key < cur_key_ff) begin
               d_key = rd_key;
               d_h = rd_h;
               d_i = lft[SW-1:0];
            end else begin
               d_key = cur_key_ff;
               d_h = cur_h_ff;
               d_i = i_ff;
            end
            best_key_in = d_key;
            best_h_in = d_h;
            best_i_in = d_i;
            if (rgt <= {1'b0, count_ff}) begin
               heap_ra = rgt[SW-1:0];
               state_in = S_RIGHT;
            end else begin
               decide = 1'b1;
            end
         end
         S_RIGHT: begin
            if (rd_key < best_key_ff) begin
               d_key = rd_key;
               d_h = rd_h;
               d_i = rgt[SW-1:0];
            end
            decide = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status = st_ff;
               rsp_in.handle_out = 10'(ho_ff);
               rsp_in.key_out = 32'(ko_ff);
               rsp_in.count = 8'(count_ff);
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (decide) begin
         if (d_i == i_ff) begin
            place = 1'b1;
         end else begin
            heap_we = 1'b1;
            heap_wa = i_ff;
            heap_wd = {d_key, d_h};
            hs_we = 1'b1;
            hs_wa = d_h;
            hs_wd = i_ff;
            i_in = d_i;
            state_in = S_DOWN;
         end
      end

      if (place) begin
         heap_we = 1'b1;
         heap_wa = i_ff;
         heap_wd = {cur_key_ff, cur_h_ff};
         hs_we = 1'b1;
         hs_wa = cur_h_ff;
         hs_wd = i_ff;
         state_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         nf_ff <= NW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         nf_ff <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      i_ff <= i_in;
      key_ff <= key_in;
      cur_key_ff <= cur_key_in;
      cur_h_ff <= cur_h_in;
      best_key_ff <= best_key_in;
      best_h_ff <= best_h_in;
      best_i_ff <= best_i_in;
      st_ff <= st_in;
      ho_ff <= ho_in;
      ko_ff <= ko_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_handles_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> nf_ff >= $past(nf_ff))
      else $error("next free handle went backward");

   a_hole_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP || state_ff == S_DOWN) |-> i_ff != '0)
      else $error("sift position is slot zero");
`endif

endmodule
`default_nettype wire
